// ----- hw/rtl/acaws_pkg.sv -----
// Shared types, opcodes and field layout for the conditional ALU with shifter.
package acaws_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 8;

  // Flag bit positions inside the NZCV register
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } alu_op_t;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
    COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
    COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
    COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
  } cond_t;

  typedef enum logic [2:0] {
    SK_IMM = 3'd0, SK_REG = 3'd1, SK_LSL = 3'd2, SK_LSR = 3'd3,
    SK_ASR = 3'd4, SK_ROR = 3'd5, SK_RRX = 3'd6
  } shift_kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_NV       = 2'd1,
    FAULT_PC_FLAGS = 2'd2
  } fault_t;

  // Decoded instruction held in the input register
  typedef struct packed {
    alu_op_t          func;
    cond_t            cond_code;
    logic             set_flags;
    logic             dest_is_pc;
    shift_kind_t      shift_kind;
    logic [AmtW-1:0]  shift_amount;
    logic             imm_rotated;
    logic [DataW-1:0] first_operand;
    logic [DataW-1:0] second_operand;
  } instr_t;

  // Shifter operand and its carry-out
  typedef struct packed {
    logic [DataW-1:0] op2;
    logic             carry;
  } shift_res_t;

  // Everything one instruction produces
  typedef struct packed {
    logic [DataW-1:0] alu_value;
    logic             write_dest;
    logic [3:0]       nzcv;
    fault_t           fault;
  } exec_res_t;

endpackage

// ----- hw/rtl/acaws_shifter.sv -----
// Barrel shifter: forms the second ALU operand and the shifter carry-out.
module acaws_shifter
  import acaws_pkg::*;
(
  input  shift_kind_t      shift_kind,
  input  logic [AmtW-1:0]  shift_amount,
  input  logic             imm_rotated,
  input  logic [DataW-1:0] operand,
  input  logic             carry_in,
  output shift_res_t       result
);

  logic [4:0]              amt_lo;
  logic                    amt_zero;
  logic                    amt_32;
  logic                    amt_big;
  logic [DataW:0]          lsl_w;
  logic [DataW:0]          lsr_w;
  logic signed [DataW:0]   asr_w;
  logic [2*DataW-1:0]      ror_w;

  assign amt_lo   = shift_amount[4:0];
  assign amt_zero = (shift_amount == '0);
  assign amt_32   = (shift_amount == AmtW'(DataW));
  assign amt_big  = (shift_amount > AmtW'(DataW));

  // Widened shifts keep the last bit shifted out next to the result
  assign lsl_w = {1'b0, operand} << amt_lo;
  assign lsr_w = {operand, 1'b0} >> amt_lo;
  assign asr_w = $signed({operand, 1'b0}) >>> amt_lo;
  assign ror_w = {operand, operand} >> amt_lo;

  // Select operand and carry by shift kind
  always_comb begin
    result.op2   = operand;
    result.carry = carry_in;
    case (shift_kind)
      SK_IMM: begin
        if (imm_rotated) result.carry = operand[DataW-1];
      end
      SK_LSL: begin
        if (amt_32) begin
          result.op2   = '0;
          result.carry = operand[0];
        end else if (amt_big) begin
          result.op2   = '0;
          result.carry = 1'b0;
        end else if (!amt_zero) begin
          result.op2   = lsl_w[DataW-1:0];
          result.carry = lsl_w[DataW];
        end
      end
      SK_LSR: begin
        if (amt_32) begin
          result.op2   = '0;
          result.carry = operand[DataW-1];
        end else if (amt_big) begin
          result.op2   = '0;
          result.carry = 1'b0;
        end else if (!amt_zero) begin
          result.op2   = lsr_w[DataW:1];
          result.carry = lsr_w[0];
        end
      end
      SK_ASR: begin
        if (amt_32 || amt_big) begin
          result.op2   = {DataW{operand[DataW-1]}};
          result.carry = operand[DataW-1];
        end else if (!amt_zero) begin
          result.op2   = asr_w[DataW:1];
          result.carry = asr_w[0];
        end
      end
      SK_ROR: begin
        // Bit 31 of the rotated word is the last bit rotated out
        if (!amt_zero) begin
          result.op2   = ror_w[DataW-1:0];
          result.carry = ror_w[DataW-1];
        end
      end
      SK_RRX: begin
        result.op2   = {carry_in, operand[DataW-1:1]};
        result.carry = operand[0];
      end
      default: begin
        result.op2   = operand;
        result.carry = carry_in;
      end
    endcase
  end

endmodule

// ----- hw/rtl/acaws_alu.sv -----
// Condition check, ALU opcodes and next NZCV for one instruction.
module acaws_alu
  import acaws_pkg::*;
(
  input  instr_t     instr,
  input  logic [3:0] nzcv,
  input  shift_res_t shift,
  output exec_res_t  result
);

  logic             n, z, c, v;
  logic             cond_pass;
  logic             is_compare;
  logic [DataW-1:0] add_x;
  logic [DataW-1:0] add_y;
  logic             add_cin;
  logic [DataW:0]   sum;
  logic             add_ovf;
  logic             is_arith;
  logic [DataW-1:0] res;
  logic             c_new;
  logic             v_new;
  logic             upd;

  assign n = nzcv[FlagN];
  assign z = nzcv[FlagZ];
  assign c = nzcv[FlagC];
  assign v = nzcv[FlagV];

  // Evaluate the condition field against the current flags
  always_comb begin
    unique case (instr.cond_code)
      COND_EQ: cond_pass = z;
      COND_NE: cond_pass = !z;
      COND_CS: cond_pass = c;
      COND_CC: cond_pass = !c;
      COND_MI: cond_pass = n;
      COND_PL: cond_pass = !n;
      COND_VS: cond_pass = v;
      COND_VC: cond_pass = !v;
      COND_HI: cond_pass = c && !z;
      COND_LS: cond_pass = !c || z;
      COND_GE: cond_pass = (n == v);
      COND_LT: cond_pass = (n != v);
      COND_GT: cond_pass = !z && (n == v);
      COND_LE: cond_pass = z || (n != v);
      COND_AL: cond_pass = 1'b1;
      COND_NV: cond_pass = 1'b0;
      default: cond_pass = 1'b0;
    endcase
  end

  // Steer operands into the single adder
  always_comb begin
    add_x    = instr.first_operand;
    add_y    = shift.op2;
    add_cin  = 1'b0;
    is_arith = 1'b1;
    unique case (instr.func)
      OP_SUB, OP_CMP: begin
        add_y   = ~shift.op2;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_x   = shift.op2;
        add_y   = ~instr.first_operand;
        add_cin = 1'b1;
      end
      OP_ADD, OP_CMN: add_cin = 1'b0;
      OP_ADC: add_cin = c;
      OP_SBC: begin
        add_y   = ~shift.op2;
        add_cin = c;
      end
      OP_RSC: begin
        add_x   = shift.op2;
        add_y   = ~instr.first_operand;
        add_cin = c;
      end
      default: is_arith = 1'b0;
    endcase
  end

  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_ovf = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ sum[DataW-1]);

  // Logical opcodes and result flags
  always_comb begin
    res = sum[DataW-1:0];
    case (instr.func)
      OP_AND, OP_TST: res = instr.first_operand & shift.op2;
      OP_EOR, OP_TEQ: res = instr.first_operand ^ shift.op2;
      OP_ORR:         res = instr.first_operand | shift.op2;
      OP_MOV:         res = shift.op2;
      OP_BIC:         res = instr.first_operand & ~shift.op2;
      OP_MVN:         res = ~shift.op2;
      default:        res = sum[DataW-1:0];
    endcase
    c_new = is_arith ? sum[DataW] : shift.carry;
    v_new = is_arith ? add_ovf : v;
  end

  assign is_compare = (instr.func == OP_TST) || (instr.func == OP_TEQ) ||
                      (instr.func == OP_CMP) || (instr.func == OP_CMN);

  // Decide write, flag update and fault
  always_comb begin
    result.alu_value  = '0;
    result.write_dest = 1'b0;
    result.nzcv       = nzcv;
    result.fault      = FAULT_NONE;
    upd               = 1'b0;
    if (instr.cond_code == COND_NV) begin
      result.fault = FAULT_NV;
    end else if (cond_pass) begin
      if (is_compare) begin
        upd = 1'b1;
      end else begin
        result.write_dest = 1'b1;
        result.alu_value  = res;
        if (instr.set_flags && instr.dest_is_pc) result.fault = FAULT_PC_FLAGS;
        else if (instr.set_flags) upd = 1'b1;
      end
    end
    if (upd) result.nzcv = {res[DataW-1], (res == '0), c_new, v_new};
  end

endmodule

// ----- hw/rtl/arm_conditional_alu_with_shifter.sv -----
// Top level: execute stage for ARM data-processing instructions with NZCV state.
//
// Usage:
//   s_axis carries one decoded instruction per item (condition, opcode, S bit,
//   shift controls and both operand values); m_axis returns one result item per
//   instruction: ALU value, write enable, the NZCV flags after the instruction
//   and a fault code (NV condition, or a flag-setting write to the PC).
//   Shift rules are the same for immediate and register amounts.
// Timing:
//   An item lands in the input register, passes the shifter, condition check
//   and adder combinationally, and lands in the result register, which drives
//   m_axis_tvalid. One item per cycle is sustained while m_axis_tready is high;
//   the flag register is written as each item moves to the result register,
//   so the next item sees the updated flags with no bubble.
// Reset:
//   rst (synchronous, active high) clears both valid bits and the NZCV flags.
// Back-pressure:
//   While m_axis_tready is low a valid result holds and an item behind it
//   stays in the input register; s_axis_tready drops only when both are full.
module arm_conditional_alu_with_shifter
  import acaws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[3:0] cond_code[7:4] set_flags[8] dest_is_pc[9] shift_kind[12:10]
  // shift_by_reg[13] shift_amount[21:14] imm_rotated[22]
  // first_operand[54:23] second_operand[86:55], zero fill to 88 bits
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // alu_value[31:0] write_dest[32] flag_neg[33] flag_zero[34] flag_carry[35]
  // flag_ovf[36] fault[38:37], zero fill to 40 bits
  output logic [39:0] m_axis_tdata
);

  instr_t     in_reg;
  logic       in_valid;
  exec_res_t  out_reg;
  logic       out_valid;
  logic [3:0] nzcv;
  logic       advance;
  shift_res_t shift_res;
  exec_res_t  exec_res;

  // Move the input item forward when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_reg.func           <= alu_op_t'(s_axis_tdata[3:0]);
      in_reg.cond_code      <= cond_t'(s_axis_tdata[7:4]);
      in_reg.set_flags      <= s_axis_tdata[8];
      in_reg.dest_is_pc     <= s_axis_tdata[9];
      in_reg.shift_kind     <= shift_kind_t'(s_axis_tdata[12:10]);
      in_reg.shift_amount   <= s_axis_tdata[21:14];
      in_reg.imm_rotated    <= s_axis_tdata[22];
      in_reg.first_operand  <= s_axis_tdata[54:23];
      in_reg.second_operand <= s_axis_tdata[86:55];
    end
  end

  acaws_shifter u_shifter (
    .shift_kind   (in_reg.shift_kind),
    .shift_amount (in_reg.shift_amount),
    .imm_rotated  (in_reg.imm_rotated),
    .operand      (in_reg.second_operand),
    .carry_in     (nzcv[FlagC]),
    .result       (shift_res)
  );

  acaws_alu u_alu (
    .instr  (in_reg),
    .nzcv   (nzcv),
    .shift  (shift_res),
    .result (exec_res)
  );

  // Flags and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      nzcv      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        nzcv      <= exec_res.nzcv;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_reg <= exec_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_reg.fault, out_reg.nzcv[FlagV], out_reg.nzcv[FlagC],
                          out_reg.nzcv[FlagZ], out_reg.nzcv[FlagN], out_reg.write_dest,
                          out_reg.alu_value};

`ifndef ASSERT_OFF
  // A shown result always carries the flags the next instruction will see
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.nzcv == nzcv))
    else $error("result flags differ from flag register");

  // Flags change only when an item moves to the result register
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(nzcv))
    else $error("flags changed without an item advancing");

  // An NV instruction never writes a destination
  a_nv_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.fault == FAULT_NV) |-> !out_reg.write_dest)
    else $error("NV condition wrote a destination");

  // A result without a write carries a zero value
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.write_dest) |-> (out_reg.alu_value == '0))
    else $error("nonzero value without a destination write");
`endif

endmodule
